### hdl/dmm_pkg.sv
// Shared widths and types for the dense matrix multiply block.
`default_nettype none

package dmm_pkg;

  // Field widths fixed by the element and result formats
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 64;
  localparam int SIZE_W       = 4;
  localparam int IDX_W        = 3;
  // Store address width wide enough for the largest supported matrix
  localparam int STORE_ADDR_W = 8;
  // Accumulator carries enough headroom for up to fifteen exact products
  localparam int ACC_W        = PROD_W + SIZE_W;

  // Effective matrix sizes, already clamped to the legal range
  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] inner;
    logic [SIZE_W-1:0] cols;
  } sizes_t;

  // One classified element on its way from the front to the back
  typedef struct packed {
    logic                     is_b;
    logic                     last;
    logic [STORE_ADDR_W-1:0]  addr;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/dmm_front.sv
// Front end: accepts elements, classifies them as A or B and tags the last one.
`default_nettype none

module dmm_front #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dmm_pkg::sizes_t               sizes,
  input  wire logic                          restart,
  input  wire logic                          push,
  input  wire logic [dmm_pkg::DATA_W-1:0]    in_element_value,
  output logic                               full,
  output logic                               cmd_push,
  output dmm_pkg::cmd_t                      cmd,
  input  wire logic                          cmd_full
);
  import dmm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CNT_W = $clog2(2 * DEPTH);
  localparam int LEN_W = 2 * SIZE_W + 1;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [LEN_W-1:0] cnt_ext;
  logic [LEN_W-1:0] a_len;
  logic [LEN_W-1:0] total;
  logic             is_b;
  logic             is_last;
  logic             accept;

  // Work out the load layout from the sizes
  assign a_len   = LEN_W'(sizes.rows) * LEN_W'(sizes.inner);
  assign total   = a_len + LEN_W'(sizes.inner) * LEN_W'(sizes.cols);
  assign cnt_ext = LEN_W'(cnt_r);

  // Classify the current beat
  assign is_b    = (cnt_ext >= a_len);
  assign is_last = (cnt_ext == total - LEN_W'(1));
  assign accept  = push && !cmd_full;

  assign full     = cmd_full;
  assign cmd_push = accept;

  always_comb begin
    cmd.is_b = is_b;
    cmd.last = is_last;
    cmd.addr = is_b ? STORE_ADDR_W'(cnt_ext - a_len) : STORE_ADDR_W'(cnt_ext);
    cmd.data = in_element_value;
  end

  // Advance the load count, wrap after the last element of B, clear it on a restart
  always_comb begin
    cnt_nxt = cnt_r;
    priority if (restart) begin
      cnt_nxt = '0;
    end else if (accept) begin
      cnt_nxt = is_last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/dmm_cmd_fifo.sv
// Short queue of classified elements between the front end and the back end.
`default_nettype none

module dmm_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dmm_pkg::cmd_t wr_data,
  output logic               full,
  input  wire logic          pop,
  output dmm_pkg::cmd_t      rd_data,
  output logic               empty
);
  import dmm_pkg::*;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (PTR_W + 1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Store an incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/dmm_back.sv
// Back end: writes the matrix stores and runs the multiply-accumulate engine.
`default_nettype none

module dmm_back #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dmm_pkg::sizes_t              sizes,
  input  wire logic                         cmd_empty,
  input  wire dmm_pkg::cmd_t                cmd,
  output logic                              cmd_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [dmm_pkg::PROD_W-1:0]        out_product_value,
  output logic [dmm_pkg::IDX_W-1:0]         out_result_row,
  output logic [dmm_pkg::IDX_W-1:0]         out_result_col,
  output logic                              out_last_result
);
  import dmm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  // Matrix stores
  logic signed [DATA_W-1:0] a_mem [DEPTH];
  logic signed [DATA_W-1:0] b_mem [DEPTH];

  logic [1:0]              state_r, state_nxt;
  logic [SIZE_W-1:0]       i_r, i_nxt;
  logic [SIZE_W-1:0]       j_r, j_nxt;
  logic [SIZE_W-1:0]       k_r, k_nxt;
  logic [STORE_ADDR_W-1:0] a_base_r, a_base_nxt;
  logic [STORE_ADDR_W-1:0] a_ptr_r, a_ptr_nxt;
  logic [STORE_ADDR_W-1:0] b_ptr_r, b_ptr_nxt;

  logic                     v1_r, first1_r, last1_r;
  logic                     v2_r, first2_r, last2_r;
  logic signed [DATA_W-1:0] a_rd_r;
  logic signed [DATA_W-1:0] b_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_sum;
  logic [PROD_W-1:0]        sat_value;

  logic out_valid_r;
  logic issue;
  logic k_last, i_last, j_last;
  logic out_free;
  logic out_load;
  logic wr_a, wr_b;

  assign cmd_pop  = (state_r == S_LOAD) && !cmd_empty;
  assign wr_a     = cmd_pop && !cmd.is_b;
  assign wr_b     = cmd_pop && cmd.is_b;
  assign issue    = (state_r == S_ISSUE);
  assign k_last   = (k_r == sizes.inner - SIZE_W'(1));
  assign i_last   = (i_r == sizes.rows - SIZE_W'(1));
  assign j_last   = (j_r == sizes.cols - SIZE_W'(1));
  assign out_free = !out_valid_r || pop;
  assign out_load = (state_r == S_OUT) && out_free;

  // Sequence loading, issuing, draining and output per result element
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    a_base_nxt = a_base_r;
    a_ptr_nxt  = a_ptr_r;
    b_ptr_nxt  = b_ptr_r;
    unique case (state_r)
      S_LOAD: begin
        if (cmd_pop && cmd.last) begin
          state_nxt  = S_ISSUE;
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          a_base_nxt = '0;
          a_ptr_nxt  = '0;
          b_ptr_nxt  = '0;
        end
      end
      S_ISSUE: begin
        a_ptr_nxt = a_ptr_r + STORE_ADDR_W'(1);
        b_ptr_nxt = b_ptr_r + STORE_ADDR_W'(sizes.cols);
        k_nxt     = k_r + SIZE_W'(1);
        if (k_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (v2_r && last2_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          k_nxt = '0;
          if (j_last) begin
            j_nxt      = '0;
            i_nxt      = i_r + SIZE_W'(1);
            a_base_nxt = a_base_r + STORE_ADDR_W'(sizes.inner);
            a_ptr_nxt  = a_base_r + STORE_ADDR_W'(sizes.inner);
            b_ptr_nxt  = '0;
          end else begin
            j_nxt     = j_r + SIZE_W'(1);
            a_ptr_nxt = a_base_r;
            b_ptr_nxt = STORE_ADDR_W'(j_r) + STORE_ADDR_W'(1);
          end
          state_nxt = (i_last && j_last) ? S_LOAD : S_ISSUE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    a_base_r <= a_base_nxt;
    a_ptr_r  <= a_ptr_nxt;
    b_ptr_r  <= b_ptr_nxt;
  end

  // Write stores, read operands, multiply
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[cmd.addr[ADDR_W-1:0]] <= cmd.data;
    end
    if (wr_b) begin
      b_mem[cmd.addr[ADDR_W-1:0]] <= cmd.data;
    end
    if (issue) begin
      a_rd_r <= a_mem[a_ptr_r[ADDR_W-1:0]];
      b_rd_r <= b_mem[b_ptr_r[ADDR_W-1:0]];
    end
    prod_r <= a_rd_r * b_rd_r;
  end

  // Track operand beats through the read and multiply stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
    first1_r <= (k_r == '0);
    last1_r  <= k_last;
    first2_r <= first1_r;
    last2_r  <= last1_r;
  end

  // Accumulate exact products, restart on the first term
  assign acc_sum = (first2_r ? '0 : acc_r) +
                   {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= acc_sum;
    end
  end

  // Saturate the sum to the signed 64-bit range
  always_comb begin
    if ((&acc_r[ACC_W-1:PROD_W-1]) || !(|acc_r[ACC_W-1:PROD_W-1])) begin
      sat_value = acc_r[PROD_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_value = {1'b1, {(PROD_W - 1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(PROD_W - 1){1'b1}}};
    end
  end

  // Hold the result beat until it is popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_product_value <= sat_value;
      out_result_row    <= i_r[IDX_W-1:0];
      out_result_col    <= j_r[IDX_W-1:0];
      out_last_result   <= i_last && j_last;
    end
  end

  assign empty = !out_valid_r;

endmodule

`default_nettype wire

### hdl/dense_matrix_multiply.sv
// Top level of the dense matrix multiply block: size registers and the two halves.
//
//   channel   direction  handshake                 payload
//   input     in         push / full               in_element_value (32, signed Q16.16)
//   result    out        empty / pop               out_product_value, out_result_row,
//                                                   out_result_col, out_last_result
//   config    in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// Loading takes one element per cycle while the queue has room; a four-entry queue
// separates the front end from the store writes. After the last element of B the
// single multiply-accumulate unit works out each result in turn: it reads the
// inner_dim operand pairs, multiplies and accumulates the last term, then outputs the result.
// Reset is synchronous and clears control state only; the stores need no clearing pass.
// A held result stalls the engine; elements keep entering until the queue fills.
`default_nettype none

module dense_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [dmm_pkg::DATA_W-1:0]  in_element_value,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [dmm_pkg::PROD_W-1:0]       out_product_value,
  output logic [dmm_pkg::IDX_W-1:0]        out_result_row,
  output logic [dmm_pkg::IDX_W-1:0]        out_result_col,
  output logic                             out_last_result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import dmm_pkg::*;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  logic [SIZE_W-1:0] rows_a_r;
  logic [SIZE_W-1:0] inner_dim_r;
  logic [SIZE_W-1:0] cols_b_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;
  logic              restart;
  sizes_t            sizes;
  cmd_t              front_cmd;
  cmd_t              back_cmd;
  logic              cmd_push;
  logic              cmd_full;
  logic              cmd_pop;
  logic              cmd_empty;

  // Clamp a size register to 1..MAX_DIM
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input int max_dim);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > max_dim) begin
      res = SIZE_W'(max_dim);
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && ((reg_idx == REG_ROWS_A) || (reg_idx == REG_INNER_DIM) ||
                              (reg_idx == REG_COLS_B));

  // Write the size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= SIZE_W'(8);
      inner_dim_r <= SIZE_W'(8);
      cols_b_r    <= SIZE_W'(8);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROWS_A:    rows_a_r    <= pwdata[SIZE_W-1:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[SIZE_W-1:0];
        REG_COLS_B:    cols_b_r    <= pwdata[SIZE_W-1:0];
        default:       ;
      endcase
    end
  end

  // Read back the size registers
  always_comb begin
    unique case (reg_idx)
      REG_ROWS_A:    prdata = 32'(rows_a_r);
      REG_INNER_DIM: prdata = 32'(inner_dim_r);
      REG_COLS_B:    prdata = 32'(cols_b_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    sizes.rows  = eff_size(rows_a_r, MAX_DIM);
    sizes.inner = eff_size(inner_dim_r, MAX_DIM);
    sizes.cols  = eff_size(cols_b_r, MAX_DIM);
  end

  dmm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .sizes            (sizes),
    .restart          (restart),
    .push             (push),
    .in_element_value (in_element_value),
    .full             (full),
    .cmd_push         (cmd_push),
    .cmd              (front_cmd),
    .cmd_full         (cmd_full)
  );

  dmm_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (back_cmd),
    .empty   (cmd_empty)
  );

  dmm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .sizes             (sizes),
    .cmd_empty         (cmd_empty),
    .cmd               (back_cmd),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .out_product_value (out_product_value),
    .out_result_row    (out_result_row),
    .out_result_col    (out_result_col),
    .out_last_result   (out_last_result)
  );

endmodule

`default_nettype wire
